/* sv/xbc_pkg.sv */
package xbc_pkg;

   localparam logic [31:0] DELTA = 32'h9E37_79B9;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned ADDR_WIDTH = 4;

   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   typedef enum logic [1:0] {
      REG_KEY_WORD_0 = 2'd0,
      REG_KEY_WORD_1 = 2'd1,
      REG_KEY_WORD_2 = 2'd2,
      REG_KEY_WORD_3 = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic        valid;
      logic        op;
      logic [31:0] d0;
      logic [31:0] d1;
   } stage_type;

endpackage

/* sv/xbc_key_regs.sv */
module xbc_key_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [xbc_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output xbc_pkg::key_type                    key
);

   xbc_pkg::key_type      key_ff;
   xbc_pkg::key_type      key_in;
   xbc_pkg::reg_index_type reg_sel;

   assign reg_sel = xbc_pkg::reg_index_type'(paddr[3:2]);
   assign pready  = 1'b1;
   assign prdata  = key_ff[paddr[3:2]];
   assign key     = key_ff;

   always_comb begin
      key_in = key_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            xbc_pkg::REG_KEY_WORD_0: key_in[0] = pwdata;
            xbc_pkg::REG_KEY_WORD_1: key_in[1] = pwdata;
            xbc_pkg::REG_KEY_WORD_2: key_in[2] = pwdata;
            xbc_pkg::REG_KEY_WORD_3: key_in[3] = pwdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

/* sv/xbc_half_round.sv */
module xbc_half_round #(
   parameter logic [31:0] ENC_SUM = 32'd0,
   parameter logic [31:0] DEC_SUM = 32'd0,
   parameter logic        ODD     = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  xbc_pkg::key_type   key,
   input  xbc_pkg::stage_type stage_i,
   output xbc_pkg::stage_type stage_o
);

   // even half: encrypt updates d0 from d1 (key by sum[1:0]),
   //            decrypt updates d1 from d0 (key by sum[12:11]); odd half swaps
   localparam logic [1:0] ENC_SEL = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
   localparam logic [1:0] DEC_SEL = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

   function automatic logic [31:0] mix_word(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   xbc_pkg::stage_type stage_ff;
   xbc_pkg::stage_type stage_in;
   logic               flip;
   logic [31:0]        target;
   logic [31:0]        source;
   logic [31:0]        rkey;
   logic [31:0]        fval;
   logic [31:0]        result;

   always_comb begin
      flip   = stage_i.op ^ ODD;
      target = flip ? stage_i.d1 : stage_i.d0;
      source = flip ? stage_i.d0 : stage_i.d1;
      rkey   = stage_i.op ? (DEC_SUM + key[DEC_SEL]) : (ENC_SUM + key[ENC_SEL]);
      fval   = mix_word(source) ^ rkey;
      result = stage_i.op ? (target - fval) : (target + fval);
      stage_in = stage_i;
      if (flip) begin
         stage_in.d1 = result;
      end else begin
         stage_in.d0 = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* sv/xtea_block_cipher.sv */
// channel   | transfer when         | payload
// ----------+-----------------------+-------------------------------------------
// req       | req_valid & !req_stall| req_op, req_word_first, req_word_second
// rsp       | rsp_valid & !rsp_stall| rsp_out_first, rsp_out_second
// csr (APB) | psel&penable&pwrite   | paddr[3:2] key word, pwdata
//
// One half-round per register stage: 2*ROUNDS stages. One transfer per cycle
// sustained unless a result stalls; the half-round adder chain sets the clock.
// Synchronous reset clears the key words and all stage valid bits. A stalled
// result freezes the whole pipeline; req_stall follows it. Key words are read
// live by every stage and must be written only while idle; nothing enforces it.
module xtea_block_cipher #(
   parameter int ROUNDS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [31:0]                    req_word_first,
   input  logic [31:0]                    req_word_second,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_out_first,
   output logic [31:0]                    rsp_out_second,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [xbc_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int NSTAGE = 2 * ROUNDS;

   xbc_pkg::key_type   key;
   xbc_pkg::stage_type stg [NSTAGE+1];
   logic               hold;

   xbc_key_regs u_key_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   assign hold = rsp_valid && rsp_stall;
   assign req_stall = hold;

   always_comb begin
      stg[0].valid = req_valid;
      stg[0].op    = req_op;
      stg[0].d0    = req_word_first;
      stg[0].d1    = req_word_second;
   end

   for (genvar h = 0; h < NSTAGE; h++) begin : g_stage
      localparam logic [63:0] ENC_P = 64'(xbc_pkg::DELTA) * 64'((h + 1) / 2);
      localparam logic [63:0] DEC_P = 64'(xbc_pkg::DELTA) * 64'(ROUNDS - (h + 1) / 2);
      xbc_half_round #(
         .ENC_SUM (ENC_P[31:0]),
         .DEC_SUM (DEC_P[31:0]),
         .ODD     (1'((h % 2)))
      ) u_half_round (
         .clock   (clock),
         .reset   (reset),
         .advance (!hold),
         .key     (key),
         .stage_i (stg[h]),
         .stage_o (stg[h+1])
      );
   end

   assign rsp_valid      = stg[NSTAGE].valid;
   assign rsp_out_first  = stg[NSTAGE].d0;
   assign rsp_out_second = stg[NSTAGE].d1;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stg[1].valid)
      else $error("accepted transfer did not enter first stage");

   a_bubble_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (!hold && !stg[NSTAGE-1].valid) |=> !rsp_valid)
      else $error("result appeared from an empty stage");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      hold |=> $stable(stg[1]))
      else $error("first stage changed while stalled");

endmodule

/* test/tb_top.sv */
module tb_top;

   localparam int ROUNDS      = 32;
   localparam int LATENCY     = 2 * ROUNDS;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] second;
   } block_pair_type;

   class cipher_tracker;
      bit [31:0] key_words [xbc_pkg::KEY_WORDS];
      block_pair_type pending_blocks [$];
      int        errors;

      function bit [31:0] mix(bit [31:0] v);
         return ((v << 4) ^ (v >> 5)) + v;
      endfunction

      function block_pair_type xtea_transform(bit op, bit [31:0] a, bit [31:0] b);
         bit [31:0] s;
         block_pair_type res;
         if (!op) begin
            s = '0;
            for (int r = 0; r < ROUNDS; r++) begin
               a += mix(b) ^ (s + key_words[s[1:0]]);
               s += xbc_pkg::DELTA;
               b += mix(a) ^ (s + key_words[s[12:11]]);
            end
         end else begin
            s = 32'(xbc_pkg::DELTA * ROUNDS);
            for (int r = 0; r < ROUNDS; r++) begin
               b -= mix(a) ^ (s + key_words[s[12:11]]);
               s -= xbc_pkg::DELTA;
               a -= mix(b) ^ (s + key_words[s[1:0]]);
            end
         end
         res.first  = a;
         res.second = b;
         return res;
      endfunction

      function void set_key(xbc_pkg::reg_index_type idx, bit [31:0] value);
         key_words[idx] = value;
      endfunction

      function void note_block(bit op, bit [31:0] a, bit [31:0] b);
         pending_blocks.push_back(xtea_transform(op, a, b));
      endfunction

      function void check_block(logic [31:0] a, logic [31:0] b);
         block_pair_type want;
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected transfer %h %h", $time, a, b);
            errors++;
            return;
         end
         want = pending_blocks.pop_front();
         if (a !== want.first) begin
            $display("%0t: out_first expected %h got %h", $time, want.first, a);
            errors++;
         end
         if (b !== want.second) begin
            $display("%0t: out_second expected %h got %h", $time, want.second, b);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_op;
   logic [31:0]           req_word_first;
   logic [31:0]           req_word_second;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [31:0]           rsp_out_first;
   logic [31:0]           rsp_out_second;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [xbc_pkg::ADDR_WIDTH-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   cipher_tracker tracker = new();
   int            send_idle_pct;
   int            rsp_stall_pct;
   int            hold_cycles;
   int            cycle_count;

   xtea_block_cipher #(.ROUNDS(ROUNDS)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_word_first  (req_word_first),
      .req_word_second (req_word_second),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_first   (rsp_out_first),
      .rsp_out_second  (rsp_out_second),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // write then read back one key word
   task automatic program_key(input xbc_pkg::reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_key(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         $display("%0t: key read %s expected %h got %h", $time, idx.name(), value, prdata);
         tracker.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // returns at the edge of the transfer
   task automatic send_item(input logic op, input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_word_first  <= a;
      req_word_second <= b;
      do @(posedge clock); while (req_stall);
      tracker.note_block(op, a, b);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(31);
         3:       return ~(32'h1 << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   // some blocks are the opposite transform of a random block, i.e. round trips
   task automatic send_random_item();
      logic      op;
      logic [31:0] a;
      logic [31:0] b;
      block_pair_type peer;
      op = $urandom_range(1);
      a  = pick_word();
      b  = pick_word();
      if ($urandom_range(7) == 0) begin
         peer = tracker.xtea_transform(!op, a, b);
         a    = peer.first;
         b    = peer.second;
      end
      send_item(op, a, b);
   endtask

   task automatic wait_drained();
      while (tracker.pending_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic load_key(input xbc_pkg::key_type key);
      program_key(xbc_pkg::REG_KEY_WORD_0, key[0]);
      program_key(xbc_pkg::REG_KEY_WORD_1, key[1]);
      program_key(xbc_pkg::REG_KEY_WORD_2, key[2]);
      program_key(xbc_pkg::REG_KEY_WORD_3, key[3]);
   endtask

   task automatic run_phase(input xbc_pkg::key_type key, input int send_pct,
                            input int stall_pct, input int count, input int hold);
      wait_drained();
      load_key(key);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      hold_cycles   = hold;
      repeat (count) send_random_item();
      req_valid <= 1'b0;
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_block(rsp_out_first, rsp_out_second);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL xtea_block_cipher");
      $finish;
   end

   initial begin
      block_pair_type trip;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= 1'b0;
      req_word_first  <= '0;
      req_word_second <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_cycles     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      load_key('0);
      send_item(1'b0, 32'h0000_0000, 32'h0000_0000);
      send_item(1'b1, 32'h0000_0000, 32'h0000_0000);
      send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b0, 32'h8000_0000, 32'h0000_0001);
      send_item(1'b1, 32'h0000_0001, 32'h8000_0000);
      send_item(1'b0, 32'h0123_4567, 32'h89AB_CDEF);
      send_item(1'b1, 32'h0123_4567, 32'h89AB_CDEF);
      send_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
      trip = tracker.xtea_transform(1'b0, 32'h4142_4344, 32'h4546_4748);
      send_item(1'b1, trip.first, trip.second);
      trip = tracker.xtea_transform(1'b1, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      send_item(1'b0, trip.first, trip.second);
      req_valid <= 1'b0;

      run_phase('1, 0, 0, 280, 0);
      run_phase({$urandom, $urandom, $urandom, $urandom}, 54, 0, 280, 0);
      run_phase({$urandom, $urandom, $urandom, $urandom}, 0, 54, 280, 0);
      run_phase({32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000}, 8, 8, 280, 0);
      // long receiver hold so the pipe fills and backs up the input
      run_phase({$urandom, $urandom, $urandom, $urandom}, 0, 0, 280, 300);

      wait_drained();
      repeat (LATENCY + 8) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_blocks.size() == 0)
         $display("PASS xtea_block_cipher");
      else
         $display("FAIL xtea_block_cipher");
      $finish;
   end

endmodule

/* files.f */
sv/xbc_pkg.sv
sv/xbc_key_regs.sv
sv/xbc_half_round.sv
sv/xtea_block_cipher.sv
test/tb_top.sv
